[rtl/assert_macros.svh]
// assertion helpers shared by the feature store modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define FRS_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// condition must never be seen outside reset
`define FRS_NEVER(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("%m: forbidden condition seen");

`else

`define FRS_ASSERT(name, clk, rst, prop)
`define FRS_NEVER(name, clk, rst, cond)

`endif

`endif

[rtl/frs_pkg.sv]
package frs_pkg;

   // default queue limit
   localparam int DEF_MAX_QUEUES = 64;

   // field widths
   localparam int NS_COUNT_W = 11;
   localparam int QCOUNT_W   = 16;
   localparam int VEC_W      = 17;
   localparam int SLOT_W     = 4;
   localparam int NUM_WORDS  = 9;

   localparam logic [NS_COUNT_W-1:0] NS_COUNT_RESET = 11'd1;

   // opcodes
   localparam logic OP_GET = 1'b0;
   localparam logic OP_SET = 1'b1;

   // feature identifiers
   localparam logic [7:0] FID_ARB        = 8'd1;
   localparam logic [7:0] FID_POWER      = 8'd2;
   localparam logic [7:0] FID_LBA_RANGE  = 8'd3;
   localparam logic [7:0] FID_TEMP       = 8'd4;
   localparam logic [7:0] FID_ERR_REC    = 8'd5;
   localparam logic [7:0] FID_VWC        = 8'd6;
   localparam logic [7:0] FID_NUM_QUEUES = 8'd7;
   localparam logic [7:0] FID_INT_COAL   = 8'd8;
   localparam logic [7:0] FID_INT_VEC    = 8'd9;
   localparam logic [7:0] FID_WRITE_ATOM = 8'd10;
   localparam logic [7:0] FID_ASYNC      = 8'd11;
   localparam logic [7:0] FID_PROGRESS   = 8'd128;

   // completion status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_FIELD = 2'd1;
   localparam logic [1:0] ST_BAD_NS    = 2'd2;

   // slots of the stored feature words
   localparam logic [SLOT_W-1:0] SLOT_ARB        = 4'd0;
   localparam logic [SLOT_W-1:0] SLOT_POWER      = 4'd1;
   localparam logic [SLOT_W-1:0] SLOT_TEMP       = 4'd2;
   localparam logic [SLOT_W-1:0] SLOT_ERR_REC    = 4'd3;
   localparam logic [SLOT_W-1:0] SLOT_VWC        = 4'd4;
   localparam logic [SLOT_W-1:0] SLOT_INT_COAL   = 4'd5;
   localparam logic [SLOT_W-1:0] SLOT_WRITE_ATOM = 4'd6;
   localparam logic [SLOT_W-1:0] SLOT_ASYNC      = 4'd7;
   localparam logic [SLOT_W-1:0] SLOT_PROGRESS   = 4'd8;
   localparam logic [SLOT_W-1:0] SLOT_NONE       = 4'd15;

   // request item
   typedef struct packed {
      logic        opcode;
      logic [7:0]  feature_id;
      logic [31:0] value;
      logic [31:0] namespace_id;
      logic [15:0] current_temp;
      logic        smart_aer_masked;
   } req_type;

   // result item
   typedef struct packed {
      logic [1:0]  status;
      logic        result_valid;
      logic [31:0] result;
      logic        raise_temp_event;
   } rsp_type;

   // write request into the vector table
   typedef struct packed {
      logic             en;
      logic [15:0]      addr;
      logic [VEC_W-1:0] data;
   } vec_wr_type;

   // slot of a feature that is simply stored and read back
   function automatic logic [SLOT_W-1:0] plain_slot(input logic [7:0] fid);
      logic [SLOT_W-1:0] slot;
      unique case (fid)
         FID_POWER:      slot = SLOT_POWER;
         FID_ERR_REC:    slot = SLOT_ERR_REC;
         FID_VWC:        slot = SLOT_VWC;
         FID_INT_COAL:   slot = SLOT_INT_COAL;
         FID_WRITE_ATOM: slot = SLOT_WRITE_ATOM;
         FID_ASYNC:      slot = SLOT_ASYNC;
         FID_PROGRESS:   slot = SLOT_PROGRESS;
         default:        slot = SLOT_NONE;
      endcase
      return slot;
   endfunction

endpackage

[rtl/frs_vec_mem.sv]
module frs_vec_mem #(
   parameter int MAX_QUEUES = frs_pkg::DEF_MAX_QUEUES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic [15:0]                   rd_addr,
   output logic [frs_pkg::VEC_W-1:0]     rd_data,
   input  frs_pkg::vec_wr_type           wr,
   output logic                          clearing
);

   localparam int DEPTH = MAX_QUEUES + 1;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   logic [frs_pkg::VEC_W-1:0] mem [0:DEPTH-1];
   logic [frs_pkg::VEC_W-1:0] rd_data_ff;
   logic                      clearing_ff, clearing_in;
   logic [AW-1:0]             clr_addr_ff, clr_addr_in;

   // clearing sweep after reset, one entry a cycle
   always_comb begin
      clearing_in = clearing_ff && (clr_addr_ff != LAST);
      clr_addr_in = clearing_ff ? clr_addr_ff + AW'(1) : clr_addr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // write port and registered read, write data forwarded on a same-address hit
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr.en) begin
         mem[wr.addr[AW-1:0]] <= wr.data;
      end
      if (rd_en) begin
         if (wr.en && (wr.addr == rd_addr)) begin
            rd_data_ff <= wr.data;
         end else begin
            rd_data_ff <= mem[rd_addr[AW-1:0]];
         end
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clearing_ff;

endmodule

[rtl/frs_exec.sv]
`include "assert_macros.svh"

module frs_exec #(
   parameter int MAX_QUEUES = frs_pkg::DEF_MAX_QUEUES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  frs_pkg::req_type                  item,
   input  logic [frs_pkg::NS_COUNT_W-1:0]    ns_count,
   input  logic [frs_pkg::VEC_W-1:0]         vec_rd_data,
   output frs_pkg::rsp_type                  rsp,
   output frs_pkg::vec_wr_type               vec_wr
);

   logic [31:0]                   words_ff [0:frs_pkg::NUM_WORDS-1];
   logic [frs_pkg::QCOUNT_W-1:0]  qcount_ff, qcount_in;
   logic                          temp_flag_ff, temp_flag_in;

   logic                          is_set;
   logic [frs_pkg::SLOT_W-1:0]    slot;
   logic [15:0]                   idx;
   logic                          word_we;
   logic [frs_pkg::SLOT_W-1:0]    word_slot;
   logic                          vec_we;
   frs_pkg::rsp_type              rsp_c;

   assign is_set = (item.opcode == frs_pkg::OP_SET);
   assign slot   = frs_pkg::plain_slot(item.feature_id);
   assign idx    = item.value[15:0];

   // decode and evaluate one item
   always_comb begin
      rsp_c        = '0;
      rsp_c.status = frs_pkg::ST_OK;
      qcount_in    = qcount_ff;
      temp_flag_in = temp_flag_ff;
      word_we      = 1'b0;
      word_slot    = frs_pkg::SLOT_ARB;
      vec_we       = 1'b0;
      if (slot != frs_pkg::SLOT_NONE) begin
         if (is_set) begin
            word_we   = 1'b1;
            word_slot = slot;
         end else begin
            rsp_c.result       = words_ff[slot];
            rsp_c.result_valid = 1'b1;
         end
      end else begin
         case (item.feature_id)
            frs_pkg::FID_ARB: begin
               // old value returned on set as well
               rsp_c.result       = words_ff[frs_pkg::SLOT_ARB];
               rsp_c.result_valid = 1'b1;
               word_we            = is_set;
               word_slot          = frs_pkg::SLOT_ARB;
            end
            frs_pkg::FID_LBA_RANGE: begin
               if ((item.namespace_id == 32'd0) ||
                   (item.namespace_id > 32'(ns_count))) begin
                  rsp_c.status = frs_pkg::ST_BAD_NS;
               end
            end
            frs_pkg::FID_NUM_QUEUES: begin
               if (is_set && (item.value >= 32'd1) &&
                   (item.value <= 32'(MAX_QUEUES))) begin
                  qcount_in = item.value[15:0];
               end
               rsp_c.result       = {qcount_in, qcount_in};
               rsp_c.result_valid = 1'b1;
            end
            frs_pkg::FID_TEMP: begin
               if (is_set) begin
                  word_we   = 1'b1;
                  word_slot = frs_pkg::SLOT_TEMP;
                  // one-shot warning, re-armed once below threshold and unmasked
                  if ((item.value <= 32'(item.current_temp)) && !temp_flag_ff) begin
                     temp_flag_in           = 1'b1;
                     rsp_c.raise_temp_event = 1'b1;
                  end else if ((item.value > 32'(item.current_temp)) &&
                               !item.smart_aer_masked) begin
                     temp_flag_in = 1'b0;
                  end
               end else begin
                  rsp_c.result       = words_ff[frs_pkg::SLOT_TEMP];
                  rsp_c.result_valid = 1'b1;
               end
            end
            frs_pkg::FID_INT_VEC: begin
               if ((idx > qcount_ff) || (32'(idx) > 32'(MAX_QUEUES))) begin
                  rsp_c.status = frs_pkg::ST_BAD_FIELD;
               end else if (is_set) begin
                  vec_we = 1'b1;
               end else begin
                  rsp_c.result       = 32'(vec_rd_data);
                  rsp_c.result_valid = 1'b1;
               end
            end
            default: begin
               rsp_c.status = frs_pkg::ST_BAD_FIELD;
            end
         endcase
      end
   end

   // state commits only when the item moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         qcount_ff    <= frs_pkg::QCOUNT_W'(MAX_QUEUES);
         temp_flag_ff <= 1'b0;
         for (int i = 0; i < frs_pkg::NUM_WORDS; i++) begin
            words_ff[i] <= '0;
         end
      end else if (advance) begin
         qcount_ff    <= qcount_in;
         temp_flag_ff <= temp_flag_in;
         if (word_we) begin
            words_ff[word_slot] <= item.value;
         end
      end
   end

   assign rsp         = rsp_c;
   assign vec_wr.en   = advance && vec_we;
   assign vec_wr.addr = idx;
   assign vec_wr.data = item.value[frs_pkg::VEC_W-1:0];

   `FRS_ASSERT(a_qcount_range, clock, reset,
      (qcount_ff != '0) && (32'(qcount_ff) <= 32'(MAX_QUEUES)))
   `FRS_ASSERT(a_raise_sets_flag, clock, reset,
      (advance && rsp_c.raise_temp_event) |=> temp_flag_ff)
   `FRS_NEVER(a_error_no_result, clock, reset,
      (rsp_c.status != frs_pkg::ST_OK) && rsp_c.result_valid)

endmodule

[rtl/feature_register_store_unit.sv]
// channel   | ports                              | item type
// ----------+------------------------------------+------------------
// request   | req_valid, req_stall, req_item     | frs_pkg::req_type
// result    | rsp_valid, rsp_stall, rsp_item     | frs_pkg::rsp_type
// register  | csr_wr_en, csr_wr_data             | namespace count
//
// one item per cycle sustained while results are not stalled; each result is registered in the
// result register after its item is taken (input register and vector table read at the same
// edge, then one evaluation step); after reset the vector table is swept to zero while
// req_stall is held high; register writes are taken throughout
// a stalled result holds one item in the input register, further items are stalled
`include "assert_macros.svh"

module feature_register_store_unit #(
   parameter int MAX_QUEUES = frs_pkg::DEF_MAX_QUEUES
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  frs_pkg::req_type               req_item,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output frs_pkg::rsp_type               rsp_item,
   input  logic                           csr_wr_en,
   input  logic [frs_pkg::NS_COUNT_W-1:0] csr_wr_data
);

   logic                           in_valid_ff, in_valid_in;
   frs_pkg::req_type               in_item_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   frs_pkg::rsp_type               rsp_item_ff;
   logic [frs_pkg::NS_COUNT_W-1:0] ns_count_ff;

   logic                           clearing;
   logic                           out_free;
   logic                           advance;
   logic                           req_accept;
   logic [frs_pkg::VEC_W-1:0]      vec_rd_data;
   frs_pkg::vec_wr_type            vec_wr;
   frs_pkg::rsp_type               exec_rsp;

   // handshake and stage movement
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign advance    = in_valid_ff && out_free;
   assign req_stall  = clearing || (in_valid_ff && !out_free);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers and namespace count
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ns_count_ff  <= frs_pkg::NS_COUNT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            ns_count_ff <= csr_wr_data;
         end
      end
   end

   // item registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         rsp_item_ff <= exec_rsp;
      end
   end

   // vector table, read as the item is taken
   frs_vec_mem #(
      .MAX_QUEUES (MAX_QUEUES)
   ) u_vec_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_accept),
      .rd_addr  (req_item.value[15:0]),
      .rd_data  (vec_rd_data),
      .wr       (vec_wr),
      .clearing (clearing)
   );

   // feature state and evaluation
   frs_exec #(
      .MAX_QUEUES (MAX_QUEUES)
   ) u_exec (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .item        (in_item_ff),
      .ns_count    (ns_count_ff),
      .vec_rd_data (vec_rd_data),
      .rsp         (exec_rsp),
      .vec_wr      (vec_wr)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   `FRS_ASSERT(a_rsp_held, clock, reset,
      (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff)
   `FRS_ASSERT(a_item_held, clock, reset,
      (in_valid_ff && !out_free) |=> in_valid_ff)
   `FRS_ASSERT(a_no_result_zero, clock, reset,
      (rsp_valid_ff && !rsp_item_ff.result_valid) |-> (rsp_item_ff.result == 32'd0))

endmodule
